// File: src/tlrq_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the three-level ready queue scheduler
package tlrq_pkg;

    localparam int PID_W       = 6;
    localparam int LINK_W      = PID_W + 1;
    localparam int CFG_IDX_W   = 4;
    localparam int QSEL_W      = 2;
    localparam int NUM_QUEUES  = 3;
    localparam int MAX_PROCS_DEF = 64;

    // request kinds
    localparam logic KIND_READY = 1'b0;
    localparam logic KIND_BLOCK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_LIMIT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_LIMIT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ID      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_ID     = 4'd3;

    // reset values of the configuration registers
    localparam logic [PID_W-1:0] RST_TASK_LIMIT   = 6'd15;
    localparam logic [PID_W-1:0] RST_SERVER_LIMIT = 6'd31;
    localparam logic [PID_W-1:0] RST_IDLE_ID      = 6'd0;
    localparam logic [PID_W-1:0] RST_CLOCK_ID     = 6'd1;

    // queue selectors
    localparam logic [QSEL_W-1:0] Q_TASK   = 2'd0;
    localparam logic [QSEL_W-1:0] Q_SERVER = 2'd1;
    localparam logic [QSEL_W-1:0] Q_USER   = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [PID_W-1:0] pid;
    } req_t;

    typedef struct packed {
        logic [PID_W-1:0] current_pid;
        logic [PID_W-1:0] billed_pid;
        logic             removed;
        logic             rescheduled;
    } res_t;

    typedef struct packed {
        logic [PID_W-1:0] task_limit;
        logic [PID_W-1:0] server_limit;
        logic [PID_W-1:0] idle_id;
        logic [PID_W-1:0] clock_id;
    } cfg_t;

    // list link: valid flag and process id
    typedef struct packed {
        logic             valid;
        logic [PID_W-1:0] pid;
    } link_t;

    localparam link_t LINK_NONE = '{valid: 1'b0, pid: '0};

    function automatic logic [QSEL_W-1:0] queue_of(input logic [PID_W-1:0] pid,
                                                    input cfg_t cfg);
        logic [QSEL_W-1:0] q;
        if (pid <= cfg.task_limit)
            q = Q_TASK;
        else if (pid <= cfg.server_limit)
            q = Q_SERVER;
        else
            q = Q_USER;
        return q;
    endfunction

endpackage

// File: src/tlrq_link_mem.sv
`timescale 1ns / 1ps
// next-link memory: one write port, one read port, registered read data
module tlrq_link_mem #(
    parameter int DEPTH = tlrq_pkg::MAX_PROCS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  tlrq_pkg::link_t       wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output tlrq_pkg::link_t       rd_data
);
    import tlrq_pkg::*;

    link_t mem [DEPTH];
    link_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/tlrq_cfg.sv
`timescale 1ns / 1ps
// configuration registers: queue limits, idle id and clock id
module tlrq_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlrq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlrq_pkg::PID_W-1:0]        cfg_data,
    output tlrq_pkg::cfg_t                    cfg
);
    import tlrq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TASK_LIMIT:   cfg_next.task_limit   = cfg_data;
                CFG_SERVER_LIMIT: cfg_next.server_limit = cfg_data;
                CFG_IDLE_ID:      cfg_next.idle_id      = cfg_data;
                CFG_CLOCK_ID:     cfg_next.clock_id     = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.task_limit   <= RST_TASK_LIMIT;
            cfg_reg.server_limit <= RST_SERVER_LIMIT;
            cfg_reg.idle_id      <= RST_IDLE_ID;
            cfg_reg.clock_id     <= RST_CLOCK_ID;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/three_level_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// top level: ready queue sequencer over the next-link memory
//
// Three FIFO ready queues (task, server, user) kept as linked lists: heads and
// tails in flip-flops, next links in a memory with one write and one read port
// and registered read data. A request is taken when start is high and busy is
// low. Its result appears on res for exactly one cycle with done high, and must
// be captured then: there is no back-pressure on the result side. A ready
// request gives its result from the dispatch state, or after a state that
// clears its own link if its queue was not empty; blocking a queue head gives
// it after reading the head's link; blocking any other entry walks the list one
// link per cycle through the link memory read port, reading at most MAX_PROCS
// entries, and then unlinks the entry if found. busy drops in the cycle done is
// shown, so the next request can be taken then. Configuration writes are always
// accepted and belong in idle periods only. The link memory is not cleared after
// reset; entries are written before they are followed.
module three_level_ready_queue_scheduler #(
    parameter int MAX_PROCS = tlrq_pkg::MAX_PROCS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tlrq_pkg::req_t                    req,
    output logic                              done,
    output tlrq_pkg::res_t                    res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlrq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlrq_pkg::PID_W-1:0]        cfg_data
);
    import tlrq_pkg::*;

    localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int SW = $clog2(MAX_PROCS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READY_SELF,
        S_HEAD_RD,
        S_WALK,
        S_UNLINK
    } state_t;

    // live link: flagged valid and naming a process the memory holds
    function automatic logic link_live(input link_t l);
        return l.valid && (32'(l.pid) < MAX_PROCS);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [PID_W-1:0] pid);
        return AW'(pid);
    endfunction

    cfg_t cfg;

    // link memory port
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    link_t         mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    link_t         mem_rd_data;

    state_t            state_reg,   state_next;
    logic              kind_reg,    kind_next;
    logic [PID_W-1:0]  pid_reg,     pid_next;
    logic [QSEL_W-1:0] q_reg,       q_next;
    logic [PID_W-1:0]  cur_reg,     cur_next;
    logic [SW-1:0]     steps_reg,   steps_next;
    link_t             head_reg [NUM_QUEUES];
    link_t             head_next [NUM_QUEUES];
    link_t             tail_reg [NUM_QUEUES];
    link_t             tail_next [NUM_QUEUES];
    logic [PID_W-1:0]  running_reg, running_next;
    logic [PID_W-1:0]  charged_reg, charged_next;
    res_t              res_reg,     res_next;
    logic              done_reg,    done_next;

    tlrq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlrq_link_mem #(
        .DEPTH (MAX_PROCS),
        .AW    (AW)
    ) u_link_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // sequencer: every memory access of a request is done before the next one
    // is taken, so reads never overlap a pending write to the same entry
    always_comb
    begin
        link_t             own_link;
        link_t             nx;
        logic [QSEL_W-1:0] q;
        logic [PID_W-1:0]  chosen;

        state_next   = state_reg;
        kind_next    = kind_reg;
        pid_next     = pid_reg;
        q_next       = q_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        running_next = running_reg;
        charged_next = charged_reg;
        res_next     = res_reg;
        done_next    = 1'b0;

        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = LINK_NONE;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        own_link = '{valid: 1'b1, pid: pid_reg};
        nx       = mem_rd_data;
        q        = queue_of(pid_reg, cfg);
        chosen   = cfg.idle_id;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = req.kind;
                    pid_next   = req.pid;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                q_next               = q;
                res_next.current_pid = running_reg;
                res_next.billed_pid  = charged_reg;
                res_next.removed     = 1'b0;
                res_next.rescheduled = 1'b0;
                if (32'(pid_reg) >= MAX_PROCS)
                begin
                    // out-of-range process id: request ignored
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (kind_reg == KIND_READY)
                begin
                    tail_next[q] = own_link;
                    if (!head_reg[q].valid)
                    begin
                        head_next[q] = own_link;
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = to_addr(pid_reg);
                        mem_wr_data  = LINK_NONE;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        // append behind the old tail, own link cleared next
                        if (link_live(tail_reg[q]))
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = to_addr(tail_reg[q].pid);
                            mem_wr_data = own_link;
                        end
                        state_next = S_READY_SELF;
                    end
                end
                else if (!head_reg[q].valid)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (head_reg[q].pid == pid_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = to_addr(pid_reg);
                    state_next  = S_HEAD_RD;
                end
                else if (!link_live(head_reg[q]))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next    = head_reg[q].pid;
                    steps_next  = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = to_addr(head_reg[q].pid);
                    state_next  = S_WALK;
                end
            end

            S_READY_SELF:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = to_addr(pid_reg);
                mem_wr_data = LINK_NONE;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_HEAD_RD:
            begin
                // unlink the head, then pick the first non-empty queue
                if (link_live(nx))
                begin
                    head_next[q_reg] = nx;
                end
                else
                begin
                    head_next[q_reg] = LINK_NONE;
                    tail_next[q_reg] = LINK_NONE;
                end
                if (head_next[Q_TASK].valid)
                    chosen = head_next[Q_TASK].pid;
                else if (head_next[Q_SERVER].valid)
                    chosen = head_next[Q_SERVER].pid;
                else if (head_next[Q_USER].valid)
                    chosen = head_next[Q_USER].pid;
                running_next = chosen;
                charged_next = (chosen != cfg.clock_id) ? chosen : running_reg;
                res_next.current_pid = running_next;
                res_next.billed_pid  = charged_next;
                res_next.removed     = 1'b1;
                res_next.rescheduled = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_WALK:
            begin
                if (!link_live(nx))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (nx.pid == pid_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = to_addr(pid_reg);
                    state_next  = S_UNLINK;
                end
                else if (steps_reg == SW'(MAX_PROCS - 1))
                begin
                    // walk bound reached: looped list, report not found
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    steps_next  = steps_reg + SW'(1);
                    cur_next    = nx.pid;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = to_addr(nx.pid);
                end
            end

            S_UNLINK:
            begin
                // predecessor skips the removed entry
                mem_wr_en   = 1'b1;
                mem_wr_addr = to_addr(cur_reg);
                if (link_live(nx))
                begin
                    mem_wr_data = nx;
                end
                else
                begin
                    mem_wr_data      = LINK_NONE;
                    tail_next[q_reg] = '{valid: 1'b1, pid: cur_reg};
                end
                res_next.removed = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            kind_reg    <= KIND_READY;
            pid_reg     <= '0;
            q_reg       <= Q_TASK;
            cur_reg     <= '0;
            steps_reg   <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= LINK_NONE;
                tail_reg[i] <= LINK_NONE;
            end
            running_reg <= '0;
            charged_reg <= '0;
            res_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            pid_reg     <= pid_next;
            q_reg       <= q_next;
            cur_reg     <= cur_next;
            steps_reg   <= steps_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            running_reg <= running_next;
            charged_reg <= charged_next;
            res_reg     <= res_next;
            done_reg    <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

    // a result comes only at the end of a request's work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    // rescheduling only follows a successful removal
    a_resched_removed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.rescheduled) |-> res.removed)
        else $error("reschedule reported without removal");

    // list walk stays within its bound
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (32'(steps_reg) < MAX_PROCS))
        else $error("list walk past its bound");

    // the current process changes only on a reschedule
    a_running_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_HEAD_RD) |=> $stable(running_reg))
        else $error("running process changed outside a reschedule");

endmodule
